// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CFQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CFQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define CFQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define CFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/cfq_pkg.sv =====
// Shared types and constants for the circular FIFO queue.
// No dependencies; used by the interfaces, controller, datapath and top.
`default_nettype none

package cfq_pkg;

   localparam int DEPTH_DEF     = 32;
   localparam int WORD_BITS_DEF = 32;

   localparam int OP_W     = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 6;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   // register index taken from the word address bit
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PRINT = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic       push_wr;
      logic       pop_take;
      logic       print_start;
      logic       walk_step;
      logic       rd_en;
      logic       out_load;
      status_type out_status;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic rsp_valid;
      logic occ_zero;
      logic full;
      logic remain_one;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/cfq_ifs.sv =====
// Valid/ready channel interfaces for queue commands and results.
// Depends on cfq_pkg for field widths.
`default_nettype none

interface cfq_req_if;
   logic                         valid;
   logic                         ready;
   logic [cfq_pkg::OP_W-1:0]     operation;
   logic [cfq_pkg::WORD_W-1:0]   push_word;

   modport source (output valid, output operation, output push_word, input ready);
   modport sink   (input valid, input operation, input push_word, output ready);
endinterface

interface cfq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cfq_pkg::STATUS_W-1:0]   status;
   logic [cfq_pkg::WORD_W-1:0]     out_word;
   logic                           last_of_run;

   modport source (output valid, output status, output out_word, output last_of_run,
                   input ready);
   modport sink   (input valid, input status, input out_word, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

// ===== design/cfq_datapath.sv =====
// Queue datapath: slot memory, head/tail/occupancy, walk counter, output register.
// Depends on cfq_pkg and assert_macros.svh; driven by cfq_ctrl commands.
`default_nettype none
`include "assert_macros.svh"

module cfq_datapath #(
   parameter int DEPTH     = cfq_pkg::DEPTH_DEF,
   parameter int WORD_BITS = cfq_pkg::WORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfq_pkg::cmd_type              cmd,
   output      cfq_pkg::stat_type             stat,
   input  wire logic [cfq_pkg::WORD_W-1:0]    push_word,
   input  wire logic                          cfg_wr,
   input  wire logic [cfq_pkg::CAP_W-1:0]     cfg_data,
   output      logic [$clog2(DEPTH+1)-1:0]    cap_value,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_valid,
   output      logic [cfq_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [cfq_pkg::WORD_W-1:0]    rsp_word,
   output      logic                          rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = cfq_pkg::CAP_W + 1;

   logic [WORD_BITS-1:0] mem [0:DEPTH-1];

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cfq_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [cfq_pkg::WORD_W-1:0]    rsp_word_ff;
   logic                          rsp_last_ff;

   // ring increment wrapping at the programmed capacity
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(idx) + CNT_W'(1);
      return (n >= cap) ? '0 : IDX_W'(n);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_cap(input logic [cfq_pkg::CAP_W-1:0] v);
      logic [CNT_W-1:0] c;
      if (v == '0) begin
         c = CNT_W'(1);
      end else if (CMP_W'(v) > CMP_W'(DEPTH)) begin
         c = CNT_W'(DEPTH);
      end else begin
         c = CNT_W'(v);
      end
      return c;
   endfunction

   assign rd_addr = cmd.walk_step ? walk_idx_ff : head_ff;

   always_comb begin
      cap_in      = cap_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      walk_idx_in = walk_idx_ff;
      remain_in   = remain_ff;
      if (cfg_wr) begin
         cap_in  = clamp_cap(cfg_data);
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end else begin
         if (cmd.push_wr) begin
            tail_in = ring_next(tail_ff, cap_ff);
            occ_in  = occ_ff + CNT_W'(1);
         end
         if (cmd.pop_take) begin
            occ_in    = occ_ff - CNT_W'(1);
            remain_in = CNT_W'(1);
            if (occ_ff == CNT_W'(1)) begin
               // drained: pointers go back to slot zero
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = ring_next(head_ff, cap_ff);
            end
         end
         if (cmd.print_start) begin
            walk_idx_in = ring_next(head_ff, cap_ff);
            remain_in   = occ_ff;
         end
         if (cmd.walk_step) begin
            walk_idx_in = ring_next(walk_idx_ff, cap_ff);
            remain_in   = remain_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CNT_W'(DEPTH);
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         walk_idx_ff  <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         walk_idx_ff  <= walk_idx_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[tail_ff] <= WORD_BITS'(push_word);
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // output payload; word is zero on error statuses
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         rsp_last_ff   <= cmd.out_last;
         rsp_word_ff   <= (cmd.out_status == cfq_pkg::STAT_OK) ?
                          cfq_pkg::WORD_W'(rd_data_ff) : '0;
      end
   end

   assign stat.rsp_valid  = rsp_valid_ff;
   assign stat.occ_zero   = (occ_ff == '0);
   assign stat.full       = (occ_ff >= cap_ff);
   assign stat.remain_one = (remain_ff == CNT_W'(1));

   assign cap_value  = cap_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_last   = rsp_last_ff;

   `CFQ_ASSERT_ALWAYS(a_occ_in_cap, clock, reset, occ_ff <= cap_ff, "occupancy above capacity")
   `CFQ_ASSERT_ALWAYS(a_head_in_ring, clock, reset, CNT_W'(head_ff) < cap_ff, "head outside ring")
   `CFQ_ASSERT_ALWAYS(a_tail_in_ring, clock, reset, CNT_W'(tail_ff) < cap_ff, "tail outside ring")
   `CFQ_ASSERT_IMPLY(a_walk_nonempty, clock, reset, cmd.walk_step, remain_ff > CNT_W'(1),
                     "walk step with no words left")

endmodule

`default_nettype wire

// ===== design/cfq_ctrl.sv =====
// Queue controller: decodes operations and sequences pop and print walks.
// Depends on cfq_pkg and assert_macros.svh; drives cfq_datapath.
`default_nettype none
`include "assert_macros.svh"

module cfq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [cfq_pkg::OP_W-1:0]   req_op,
   output      logic                       req_ready,
   input  wire logic                       rsp_ready,
   input  wire cfq_pkg::stat_type          stat,
   output      cfq_pkg::cmd_type           cmd
);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      out_free;

   // output register can take a new item this cycle
   assign out_free = !stat.rsp_valid || rsp_ready;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               unique case (cfq_pkg::op_type'(req_op))
                  cfq_pkg::OP_PUSH: begin
                     if (stat.full) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = cfq_pkg::STAT_OVERFLOW;
                        cmd.out_last   = 1'b1;
                     end else begin
                        cmd.push_wr = 1'b1;
                     end
                  end
                  cfq_pkg::OP_POP: begin
                     if (stat.occ_zero) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = cfq_pkg::STAT_UNDERFLOW;
                        cmd.out_last   = 1'b1;
                     end else begin
                        cmd.pop_take = 1'b1;
                        cmd.rd_en    = 1'b1;
                        state_in     = S_WALK;
                     end
                  end
                  cfq_pkg::OP_PRINT: begin
                     if (stat.occ_zero) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = cfq_pkg::STAT_EMPTY;
                        cmd.out_last   = 1'b1;
                     end else begin
                        cmd.print_start = 1'b1;
                        cmd.rd_en       = 1'b1;
                        state_in        = S_WALK;
                     end
                  end
                  default: begin
                     // unused code: item is consumed, nothing happens
                  end
               endcase
            end
         end
         S_WALK: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = cfq_pkg::STAT_OK;
               cmd.out_last   = stat.remain_one;
               if (stat.remain_one) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk_step = 1'b1;
                  cmd.rd_en     = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CFQ_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.out_load, out_free,
                     "output overwritten while held")
   `CFQ_ASSERT_IMPLY(a_walk_stalls_in, clock, reset, state_ff == S_WALK, !req_ready,
                     "input taken during walk")
   `CFQ_ASSERT_NEXT(a_walk_continues, clock, reset,
                    state_ff == S_WALK && cmd.out_load && !stat.remain_one,
                    state_ff == S_WALK, "walk ended early")

endmodule

`default_nettype wire

// ===== design/circular_fifo_queue_core.sv =====
// Circular FIFO queue, top level: APB capacity register, controller, datapath.
// Push: no result. Overflow/underflow/empty: result registered in the cycle after accept.
// Pop and print: first word passes the registered slot-memory read, then the output
// register, then one word per cycle while rsp is ready; input stalls until the last word loads.
// Throughput: one item per cycle for pushes and error results while rsp is ready.
// Reset: capacity = DEPTH, queue empty; slot memory contents stay undefined.
`default_nettype none

module circular_fifo_queue_core #(
   parameter int DEPTH     = cfq_pkg::DEPTH_DEF,
   parameter int WORD_BITS = cfq_pkg::WORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cfq_req_if.sink                            req,
   cfq_rsp_if.source                          rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [cfq_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [cfq_pkg::PDATA_W-1:0]   pwdata,
   output      logic [cfq_pkg::PDATA_W-1:0]   prdata,
   output      logic                          pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   cfq_pkg::cmd_type  cmd;
   cfq_pkg::stat_type stat;

   logic             cfg_sel;
   logic             cfg_wr;
   logic [CNT_W-1:0] cap_value;

   // Register file: one register (capacity) at word 0; other words read zero
   // and ignore writes. No wait states.
   assign pready  = 1'b1;
   assign cfg_sel = (paddr[cfq_pkg::PADDR_W-1] == cfq_pkg::REG_CAPACITY);
   assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
   assign prdata  = cfg_sel ? cfq_pkg::PDATA_W'(cap_value) : '0;

   // Controller: owns the input handshake and sequences pop/print walks
   cfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.operation),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: ring pointers, slot memory and the output register that
   // decouples the result side from the command side
   cfq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .push_word  (req.push_word),
      .cfg_wr     (cfg_wr),
      .cfg_data   (pwdata[cfq_pkg::CAP_W-1:0]),
      .cap_value  (cap_value),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (rsp.valid),
      .rsp_status (rsp.status),
      .rsp_word   (rsp.out_word),
      .rsp_last   (rsp.last_of_run)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_fifo_queue_core: valid/ready command and result
// channels, APB capacity writes. Depends on cfq_pkg and the cfq_req_if/cfq_rsp_if interfaces.

module tb_top;
   import cfq_pkg::*;

   localparam int SLOTS = DEPTH_DEF;

   // operation code 3 is outside op_type; the block must ignore it
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   // byte address of the capacity register (word address bit picks the register)
   localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

   localparam int STALL_CYCLES = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 12;   // pushes give no result; let them land
   localparam int IDLE_PCT = 19;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] word;
   } queue_cmd_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] word;
      logic              last;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [PADDR_W-1:0]   paddr;
   logic [PDATA_W-1:0]   pwdata;
   wire  [PDATA_W-1:0]   prdata;
   wire                  pready;

   cfq_req_if req_ch();
   cfq_rsp_if rsp_ch();

   circular_fifo_queue_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow queue: our own copy of the ring, indexes and capacity
   // ---------------------------------------------------------------
   logic [WORD_W-1:0] shadow_slots [SLOTS];
   int unsigned       shadow_head = 0;
   int unsigned       shadow_tail = 0;
   int unsigned       shadow_count = 0;
   int unsigned       shadow_cap = SLOTS;   // reset capacity is the full depth

   queue_cmd_type    pending_cmds[$];      // items waiting for the driver
   queue_result_type awaited_results[$];   // results the block still owes us

   int  mismatch_count = 0;
   bit  idling_on = 1'b1;
   bit  req_taken = 1'b0;
   int  stall_asks = 0;     // bumped by the stimulus to request a hold-off
   int  stall_served = 0;
   int  stall_left = 0;

   function automatic int unsigned ring_next(int unsigned idx);
      return (idx + 1 >= shadow_cap) ? 0 : idx + 1;
   endfunction

   function automatic void await_result(status_type st, logic [WORD_W-1:0] w, logic lst);
      queue_result_type r;
      r.status = st;
      r.word   = w;
      r.last   = lst;
      awaited_results.push_back(r);
   endfunction

   // Apply one accepted item to the shadow queue and queue up what it should emit.
   function automatic void predict_queue_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] w);
      int unsigned idx;
      case (op)
         OP_PUSH: begin
            if (shadow_count >= shadow_cap)
               await_result(STAT_OVERFLOW, '0, 1'b1);
            else begin
               shadow_slots[shadow_tail] = w;
               shadow_tail = ring_next(shadow_tail);
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0)
               await_result(STAT_UNDERFLOW, '0, 1'b1);
            else begin
               await_result(STAT_OK, shadow_slots[shadow_head], 1'b1);
               shadow_count--;
               // drained queue snaps both indexes back to slot 0
               if (shadow_count == 0) begin
                  shadow_head = 0;
                  shadow_tail = 0;
               end else
                  shadow_head = ring_next(shadow_head);
            end
         end
         OP_PRINT: begin
            if (shadow_count == 0)
               await_result(STAT_EMPTY, '0, 1'b1);
            else begin
               idx = shadow_head;
               for (int unsigned i = 0; i < shadow_count; i++) begin
                  await_result(STAT_OK, shadow_slots[idx], (i + 1 == shadow_count));
                  idx = ring_next(idx);
               end
            end
         end
         default: ;   // code 3: no result, no state change
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Driver: accept at the rising edge, present the next item at the falling edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken)
         predict_queue_op(req_ch.operation, req_ch.push_word);
   end

   always @(negedge clock) begin
      queue_cmd_type nxt;
      if (!req_ch.valid || req_taken) begin
         if (pending_cmds.size() != 0 &&
             !(idling_on && $urandom_range(0, 99) < IDLE_PCT)) begin
            nxt = pending_cmds.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.operation <= nxt.op;
            req_ch.push_word <= nxt.word;
         end else
            req_ch.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random back-pressure plus a long counted hold-off on request
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_served != stall_asks) begin
         stall_served <= stall_asks;
         stall_left   <= STALL_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= !(idling_on && $urandom_range(0, 99) < IDLE_PCT);
   end

   // ---------------------------------------------------------------
   // Monitor: every accepted result against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      queue_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: status %0d word %08h last %0b",
                   rsp_ch.status, rsp_ch.out_word, rsp_ch.last_of_run);
            mismatch_count++;
         end else begin
            exp_r = awaited_results.pop_front();
            if (rsp_ch.status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.out_word !== exp_r.word) begin
               $error("out_word: expected %08h, got %08h", exp_r.word, rsp_ch.out_word);
               mismatch_count++;
            end
            if (rsp_ch.last_of_run !== exp_r.last) begin
               $error("last_of_run: expected %0b, got %0b", exp_r.last, rsp_ch.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void queue_cmd(logic [OP_W-1:0] op, logic [WORD_W-1:0] w);
      queue_cmd_type c;
      c.op   = op;
      c.word = w;
      pending_cmds.push_back(c);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // Block is idle: nothing queued, nothing offered, nothing owed, pushes settled.
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_ch.valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; the register takes it at the access edge.
   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CAPACITY_ADDR;
      pwdata  = PDATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      // 0 reads as one slot, anything past the depth saturates
      if (value == 0)
         shadow_cap = 1;
      else if (value > SLOTS)
         shadow_cap = SLOTS;
      else
         shadow_cap = value;
      shadow_head  = 0;
      shadow_tail  = 0;
      shadow_count = 0;
   endtask

   // Random traffic: mostly push/pop/print with fill bursts so full and wrap get hit.
   task automatic queue_random_run(int n);
      int unsigned r;
      int          burst;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            burst = $urandom_range(1, shadow_cap + 2);
            for (int k = 0; k < burst; k++)
               queue_cmd(OP_PUSH, pick_word());
         end else if (r < 50)
            queue_cmd(OP_PUSH, pick_word());
         else if (r < 78)
            queue_cmd(OP_POP, pick_word());
         else if (r < 95)
            queue_cmd(OP_PRINT, pick_word());
         else
            queue_cmd(OP_IGNORED, pick_word());
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [CAP_W-1:0] caps [8];
      caps = '{6'd32, 6'd1, 6'd7, 6'd0, 6'd45, 6'd3, 6'd16, 6'd63};

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.push_word = '0;
      rsp_ch.ready     = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(posedge clock);

      // Directed, reset capacity: empty errors, ignored code, word extremes, drain
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_IGNORED, '1);
      queue_cmd(OP_PUSH, '0);
      queue_cmd(OP_PUSH, '1);
      queue_cmd(OP_PUSH, 32'h5a5a_a5a5);
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_POP, '0);
      wait_drained();

      // Capacity written as zero -> single slot, overflow on the second push
      write_capacity(6'd0);
      queue_cmd(OP_PUSH, 32'h8000_0001);
      queue_cmd(OP_PUSH, 32'h1234_5678);
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_POP, '0);
      wait_drained();

      // Two slots: overflow, then wrap of the tail past the end of the ring
      write_capacity(6'd2);
      queue_cmd(OP_PUSH, 32'h0000_00aa);
      queue_cmd(OP_PUSH, 32'h0000_00bb);
      queue_cmd(OP_PUSH, 32'h0000_00cc);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_PUSH, 32'h0000_00dd);
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_POP, '0);
      wait_drained();

      // Random phases over a spread of capacities; one phase runs with no idling
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         idling_on = (p != 2);
         queue_random_run(18);
         wait_drained();
      end
      idling_on = 1'b1;

      // Pressure: full ring, receiver holds off while prints pile up and stall input
      write_capacity(6'd32);
      for (int k = 0; k < SLOTS; k++)
         queue_cmd(OP_PUSH, pick_word());
      wait_drained();
      stall_asks++;
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_PRINT, '0);
      queue_cmd(OP_PUSH, pick_word());
      queue_cmd(OP_PUSH, pick_word());
      queue_cmd(OP_PRINT, '0);
      queue_random_run(10);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #6_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
